// ===== hdl/fpbc_pkg.sv =====
package fpbc_pkg;

   localparam int TableEntries = 2048;
   localparam int WaysPerSet   = 4;
   localparam int CounterBits  = 48;

   localparam int KeyBits   = 40;
   localparam int OutBits   = 48;
   localparam int LenBits   = 16;

   localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
   localparam logic [15:0] MinEthLength  = 16'd14;
   localparam logic [15:0] MinIpLength   = 16'd34;
   localparam logic [31:0] BroadcastAddr = 32'hFFFF_FFFF;
   localparam logic [7:0]  ProtoTcp      = 8'd6;
   localparam logic [7:0]  ProtoUdp      = 8'd17;

   localparam logic [1:0] StatusIgnored = 2'd0;
   localparam logic [1:0] StatusHit     = 2'd1;
   localparam logic [1:0] StatusNew     = 2'd2;
   localparam logic [1:0] StatusEvict   = 2'd3;

   // Request that enters the set memory after the header check.
   typedef struct packed {
      logic        counts;
      logic [39:0] key;
      logic [15:0] total_length;
   } lookup_type;

endpackage

// ===== hdl/fpbc_filter.sv =====
module fpbc_filter (
   input  logic [15:0]             frame_length,
   input  logic [15:0]             ether_type,
   input  logic [31:0]             dst_addr,
   input  logic [7:0]              ip_protocol,
   input  logic [15:0]             ip_total_length,
   output fpbc_pkg::lookup_type    lookup
);

   always_comb begin
      lookup.counts = (frame_length >= fpbc_pkg::MinEthLength)
                   && (ether_type == fpbc_pkg::EtherTypeIpv4)
                   && (frame_length >= fpbc_pkg::MinIpLength)
                   && (dst_addr != fpbc_pkg::BroadcastAddr)
                   && ((ip_protocol == fpbc_pkg::ProtoTcp)
                       || (ip_protocol == fpbc_pkg::ProtoUdp));
      lookup.key          = {dst_addr, ip_protocol};
      lookup.total_length = ip_total_length;
   end

endmodule

// ===== hdl/fpbc_set_table.sv =====
// One memory row holds a whole set; a lookup reads the row, then writes it back.
module fpbc_set_table #(
   parameter int TABLE_ENTRIES = fpbc_pkg::TableEntries,
   parameter int WAYS_PER_SET  = fpbc_pkg::WaysPerSet,
   parameter int COUNTER_BITS  = fpbc_pkg::CounterBits
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  fpbc_pkg::lookup_type   lookup,
   output logic                   busy,
   output logic                   done,
   output logic [1:0]             status,
   output logic [47:0]            packet_count,
   output logic [47:0]            byte_count
);

   localparam int NumSets  = (TABLE_ENTRIES / WAYS_PER_SET) > 0
                             ? (TABLE_ENTRIES / WAYS_PER_SET) : 1;
   localparam int SetBits  = (NumSets > 1) ? $clog2(NumSets) : 1;
   localparam int WayBits  = (WAYS_PER_SET > 1) ? $clog2(WAYS_PER_SET) : 1;
   localparam int RankBits = WayBits;
   localparam int KB       = fpbc_pkg::KeyBits;

   typedef struct packed {
      logic [KB-1:0]           key;
      logic [COUNTER_BITS-1:0] packets;
      logic [COUNTER_BITS-1:0] bytes;
   } way_type;

   typedef way_type       row_type   [WAYS_PER_SET];
   typedef logic [RankBits-1:0] rank_type [WAYS_PER_SET];

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CLEAR = 3'b010,
      ST_WRITE = 3'b100
   } state_type;

   way_type  data_mem  [NumSets][WAYS_PER_SET];
   logic [WAYS_PER_SET-1:0] valid_mem [NumSets];
   rank_type rank_mem  [NumSets];

   state_type state_ff, state_in;
   logic [SetBits-1:0] clear_ff, clear_in;
   logic [SetBits-1:0] set_ff;
   logic [KB-1:0]      key_ff;
   logic [15:0]        tlen_ff;

   way_type                 rd_data [WAYS_PER_SET];
   logic [WAYS_PER_SET-1:0] rd_valid;
   rank_type                rd_rank;

   logic [SetBits-1:0] set_index;
   always_comb begin
      logic [SetBits-1:0] mix;
      mix = SetBits'({lookup.key[39:8] ^ {24'd0, lookup.key[7:0]}});
      if (NumSets > 1)
         set_index = SetBits'(({lookup.key[39:8] ^ {24'd0, lookup.key[7:0]}}) % NumSets);
      else
         set_index = mix & '0;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rd_data  <= data_mem[set_index];
         rd_valid <= valid_mem[set_index];
         rd_rank  <= rank_mem[set_index];
         set_ff   <= set_index;
         key_ff   <= lookup.key;
         tlen_ff  <= lookup.total_length;
      end
   end

   // Way selection and update.
   logic [WayBits-1:0] way;
   logic               hit, free;
   logic [1:0]         stat;
   way_type            new_way;
   rank_type           new_rank;
   logic [RankBits-1:0] old_rank;
   logic [COUNTER_BITS-1:0] base_p, base_b;

   always_comb begin
      logic [WayBits-1:0] hway, fway, eway;
      hit = 1'b0; free = 1'b0;
      hway = '0; fway = '0; eway = '0;
      for (int w = WAYS_PER_SET - 1; w >= 0; w--) begin
         if (rd_valid[w] && rd_data[w].key == key_ff) begin
            hit = 1'b1; hway = WayBits'(w);
         end
         if (!rd_valid[w]) begin
            free = 1'b1; fway = WayBits'(w);
         end
      end
      for (int w = 1; w < WAYS_PER_SET; w++)
         if (rd_rank[w] > rd_rank[eway]) eway = WayBits'(w);
      priority if (hit) begin
         way = hway; stat = fpbc_pkg::StatusHit;
      end else if (free) begin
         way = fway; stat = fpbc_pkg::StatusNew;
      end else begin
         way = eway; stat = fpbc_pkg::StatusEvict;
      end
      old_rank = (!hit && free) ? {RankBits{1'b1}} : rd_rank[way];
      for (int w = 0; w < WAYS_PER_SET; w++) begin
         if (WayBits'(w) == way)
            new_rank[w] = '0;
         else if (rd_valid[w] && (rd_rank[w] < old_rank || (!hit && free)))
            new_rank[w] = rd_rank[w] + 1'b1;
         else
            new_rank[w] = rd_rank[w];
      end
      base_p = hit ? rd_data[way].packets : '0;
      base_b = hit ? rd_data[way].bytes   : '0;
      new_way.key     = key_ff;
      new_way.packets = base_p + COUNTER_BITS'(1);
      new_way.bytes   = base_b + COUNTER_BITS'(tlen_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         valid_mem[clear_ff] <= '0;
         rank_mem[clear_ff]  <= '{default: '0};
      end else if (state_ff == ST_WRITE) begin
         data_mem[set_ff][way]  <= new_way;
         valid_mem[set_ff]      <= rd_valid | (WAYS_PER_SET'(1) << way);
         rank_mem[set_ff]       <= new_rank;
      end
   end

   always_comb begin
      state_in = state_ff;
      clear_in = clear_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_in = clear_ff + 1'b1;
            if (clear_ff == SetBits'(NumSets - 1)) state_in = ST_IDLE;
         end
         ST_IDLE:  if (start) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clear_ff <= '0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign done         = (state_ff == ST_WRITE);
   assign status       = stat;
   assign packet_count = 48'(new_way.packets);
   assign byte_count   = 48'(new_way.bytes);

endmodule

// ===== hdl/flow_packet_byte_counter_table_core.sv =====
// Per-flow packet and byte counter table.
// The req_ channel carries the parsed header of one outgoing frame. Frames
// that are IPv4 TCP or UDP, long enough and not broadcast are counted per
// (destination address, protocol) flow in a set-associative table with exact
// least-recently-used replacement; all others are reported as ignored.
// The rsp_ channel returns one transfer per request: status and the updated
// packet and byte counts of the flow entry.
// A counted frame reads its set from memory into registers when it is
// accepted and writes it back in the write state, where the result is
// registered. Ignored frames go straight into the output register. No new
// frame is taken while a counted frame is written back, because of the
// single memory port pair's read-modify-write of one set row.
// After reset a clearing pass walks all sets (512 with the default sizes), one
// row per cycle, during which req_tready stays low.
// When the receiver stalls, the result waits in the output register and
// req_tready stays low until that result has been taken.
module flow_packet_byte_counter_table_core #(
   parameter int TABLE_ENTRIES = fpbc_pkg::TableEntries,
   parameter int WAYS_PER_SET  = fpbc_pkg::WaysPerSet,
   parameter int COUNTER_BITS  = fpbc_pkg::CounterBits
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // frame_length[15:0], ether_type[31:16], dst_addr[63:32],
   // ip_protocol[71:64], ip_total_length[87:72]
   input  logic [87:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], packet_count[49:2], byte_count[97:50], zero fill to 104
   output logic [103:0] rsp_tdata
);

   fpbc_pkg::lookup_type lookup;
   logic        busy, done;
   logic [1:0]  t_status;
   logic [47:0] t_packets, t_bytes;

   logic        out_valid_ff;
   logic [97:0] out_data_ff;
   logic        pend_ff;      // a counted frame is in the table

   fpbc_filter u_filter (
      .frame_length    (req_tdata[15:0]),
      .ether_type      (req_tdata[31:16]),
      .dst_addr        (req_tdata[63:32]),
      .ip_protocol     (req_tdata[71:64]),
      .ip_total_length (req_tdata[87:72]),
      .lookup          (lookup)
   );

   // Accept when the table is free and the output register is free or being drained.
   logic out_free, req_fire, start;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = !busy && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign start      = req_fire && lookup.counts;

   fpbc_set_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .WAYS_PER_SET  (WAYS_PER_SET),
      .COUNTER_BITS  (COUNTER_BITS)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .lookup       (lookup),
      .busy         (busy),
      .done         (done),
      .status       (t_status),
      .packet_count (t_packets),
      .byte_count   (t_bytes)
   );

   // The output register is free at done time: the table only started when it was.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         pend_ff <= start;
         if (done)
            out_valid_ff <= 1'b1;
         else if (req_fire && !lookup.counts)
            out_valid_ff <= 1'b1;
         else if (rsp_tready)
            out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done)
         out_data_ff <= {t_bytes, t_packets, t_status};
      else if (req_fire && !lookup.counts)
         out_data_ff <= {96'd0, fpbc_pkg::StatusIgnored};
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_data_ff};

   a_done_follows_start: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> done) else $error("table write-back missing after a lookup");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("request taken while table busy");
   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == fpbc_pkg::StatusIgnored) |-> rsp_tdata[97:2] == '0)
      else $error("ignored frame with nonzero counts");

endmodule
